>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro expects signals named clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/bir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bir_pkg - shared definitions of the bilinear resampler
// Field widths, item codes, register indexes and the records passed
// between the front and back parts.
// ----------------------------------------------------------------------------
package bir_pkg;

	localparam int MAX_SRC_DIM   = 256;
	localparam int MAX_DST_DIM   = 1024;
	localparam int FRAC_BITS_DEF = 16;
	localparam int SRC_AW        = $clog2(MAX_SRC_DIM);
	localparam int COORD_W       = 10;
	localparam int PIX_W         = 8;
	localparam int IN_DIM_W      = 9;
	localparam int OUT_DIM_W     = 11;
	localparam int CFG_IDX_W     = 2;
	localparam int RST_IN_DIM    = 256;
	localparam int RST_OUT_DIM   = 256;

	typedef enum logic [0:0] {
		FUNC_WRITE  = 1'b0,
		FUNC_SAMPLE = 1'b1
	} func_t;

	localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 2'd3;

	// last valid source index and last valid output coordinate per axis
	typedef struct packed {
		logic [SRC_AW-1:0]  ix_max;
		logic [SRC_AW-1:0]  iy_max;
		logic [COORD_W-1:0] ox_max;
		logic [COORD_W-1:0] oy_max;
	} lim_t;

	typedef struct packed {
		func_t              func;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		logic [PIX_W-1:0]   pix;
	} ent_t;

	// source dimension saturated to [1, MAX_SRC_DIM], minus one
	function automatic logic [SRC_AW-1:0] src_last(input logic [IN_DIM_W-1:0] v);
		logic [IN_DIM_W-1:0] r;
		if (v == '0) begin
			r = '0;
		end else if (v > IN_DIM_W'(MAX_SRC_DIM)) begin
			r = IN_DIM_W'(MAX_SRC_DIM - 1);
		end else begin
			r = v - 1'b1;
		end
		return r[SRC_AW-1:0];
	endfunction

	// output dimension saturated to [1, MAX_DST_DIM], minus one
	function automatic logic [COORD_W-1:0] dst_last(input logic [OUT_DIM_W-1:0] v);
		logic [OUT_DIM_W-1:0] r;
		if (v == '0) begin
			r = '0;
		end else if (v > OUT_DIM_W'(MAX_DST_DIM)) begin
			r = OUT_DIM_W'(MAX_DST_DIM - 1);
		end else begin
			r = v - 1'b1;
		end
		return r[COORD_W-1:0];
	endfunction

endpackage
`default_nettype wire

>>> sv/bilinear_image_resampler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_image_resampler - top level
// Source image store with a bilinear sampler behind queue-style ports.
// ----------------------------------------------------------------------------
// Items enter at one per clock while full is low and sample results leave at
// one per clock while empty is low. A write item stores pixel_in at (col, row)
// of a 256 x 256 source image; a sample item returns the bilinear value at
// output position (col, row), saturated to the output size, and echoes the raw
// col and row. A sample passes through the item queue, then the four-stage
// back pipeline (issue register, step multiply, neighbour address and store
// read, two horizontal blends), with the vertical blend on the way into the
// result queue. The store is four banks split by column and row parity, so the
// four neighbours are read in parallel. A write to a register starts the step
// dividers, one quotient bit per cycle; full and not-ready are held until both
// are done. Write registers only while the block is idle. Pixels that were
// never written read as anything.
// ----------------------------------------------------------------------------
module bilinear_image_resampler import bir_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// item side
	input  wire logic                 push,
	output logic                      full,
	input  wire logic                 func,
	input  wire logic [COORD_W-1:0]   col,
	input  wire logic [COORD_W-1:0]   row,
	input  wire logic [PIX_W-1:0]     pixel_in,
	// result side
	output logic                      empty,
	input  wire logic                 pop,
	output logic [PIX_W-1:0]          sample_value,
	output logic [COORD_W-1:0]        out_col,
	output logic [COORD_W-1:0]        out_row,
	// register writes
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [OUT_DIM_W-1:0] cfg_data
);

	localparam int STEP_W = SRC_AW + FRAC_BITS;
	// step for the reset sizes, worked out at elaboration
	localparam longint unsigned RST_STEP_L =
		(longint'(RST_IN_DIM - 1) << FRAC_BITS) / longint'(RST_OUT_DIM - 1);
	localparam logic [STEP_W-1:0] RST_STEP = STEP_W'(RST_STEP_L);

	logic [IN_DIM_W-1:0]  in_width_q, in_height_q;
	logic [OUT_DIM_W-1:0] out_width_q, out_height_q;
	logic                 start_q;
	logic                 cfg_wr;
	logic                 busy_x, busy_y, busy;
	logic [STEP_W-1:0]    step_x, step_y;
	lim_t                 lim;
	logic                 q_valid, issue;
	ent_t                 head;

	assign busy      = start_q || busy_x || busy_y;
	assign cfg_ready = !busy;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// Register file; every write kicks both dividers on the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q   <= IN_DIM_W'(RST_IN_DIM);
			in_height_q  <= IN_DIM_W'(RST_IN_DIM);
			out_width_q  <= OUT_DIM_W'(RST_OUT_DIM);
			out_height_q <= OUT_DIM_W'(RST_OUT_DIM);
			start_q      <= 1'b0;
		end else begin
			start_q <= cfg_wr;
			if (cfg_wr) begin
				unique case (cfg_index)
					REG_IN_WIDTH:   in_width_q   <= cfg_data[IN_DIM_W-1:0];
					REG_IN_HEIGHT:  in_height_q  <= cfg_data[IN_DIM_W-1:0];
					REG_OUT_WIDTH:  out_width_q  <= cfg_data;
					REG_OUT_HEIGHT: out_height_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Saturated sizes as last indexes: zero acts as one.
	always_comb begin
		lim.ix_max = src_last(in_width_q);
		lim.iy_max = src_last(in_height_q);
		lim.ox_max = dst_last(out_width_q);
		lim.oy_max = dst_last(out_height_q);
	end

	bir_div #(
		.FRAC_BITS (FRAC_BITS),
		.Q_W       (STEP_W),
		.RST_Q     (RST_STEP)
	) u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.numer  (lim.ix_max),
		.denom  (lim.ox_max),
		.quot   (step_x),
		.busy   (busy_x)
	);

	bir_div #(
		.FRAC_BITS (FRAC_BITS),
		.Q_W       (STEP_W),
		.RST_Q     (RST_STEP)
	) u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.numer  (lim.iy_max),
		.denom  (lim.oy_max),
		.quot   (step_y),
		.busy   (busy_y)
	);

	// Front: takes items and saturates sample coordinates into a short queue.
	bir_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.func     (func),
		.col      (col),
		.row      (row),
		.pixel_in (pixel_in),
		.hold     (busy),
		.lim      (lim),
		.issue    (issue),
		.q_valid  (q_valid),
		.head     (head)
	);

	// Back: writes and samples in order; issue is credit-limited by the
	// result queue, so the pipeline itself never stalls.
	bir_back #(
		.FRAC_BITS (FRAC_BITS),
		.STEP_W    (STEP_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.head         (head),
		.issue        (issue),
		.lim          (lim),
		.step_x       (step_x),
		.step_y       (step_y),
		.empty        (empty),
		.pop          (pop),
		.sample_value (sample_value),
		.out_col      (out_col),
		.out_row      (out_row)
	);

endmodule
`default_nettype wire

>>> sv/bir_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bir_div - step divider
// Restoring divider, one quotient bit per cycle: (last << FRAC) / denom.
// ----------------------------------------------------------------------------
module bir_div import bir_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int Q_W       = SRC_AW + FRAC_BITS,
	parameter logic [Q_W-1:0] RST_Q = '0
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [SRC_AW-1:0]  numer,
	input  wire logic [COORD_W-1:0] denom,
	output logic [Q_W-1:0]          quot,
	output logic                    busy
);

	localparam int CNT_W = $clog2(Q_W + 1);

	logic [COORD_W-1:0] den_q;
	logic [COORD_W-1:0] rem_q;
	logic [Q_W-1:0]     work_q;
	logic [Q_W-1:0]     res_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               run_q;

	logic [COORD_W:0]   part;
	logic               ge;
	logic [COORD_W:0]   diff;

	assign part = {rem_q, work_q[Q_W-1]};
	assign ge   = part >= {1'b0, den_q};
	assign diff = part - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			res_q <= RST_Q;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= CNT_W'(Q_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				run_q <= 1'b0;
				// a single output pixel pins the step to zero
				res_q <= (den_q == '0) ? '0 : {work_q[Q_W-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q  <= denom;
			rem_q  <= '0;
			work_q <= {numer, {FRAC_BITS{1'b0}}};
		end else if (run_q) begin
			rem_q  <= ge ? diff[COORD_W-1:0] : part[COORD_W-1:0];
			work_q <= {work_q[Q_W-2:0], ge};
		end
	end

	assign quot = res_q;
	assign busy = run_q;

endmodule
`default_nettype wire

>>> sv/bir_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bir_front - input side
// Takes items, saturates sample coordinates and queues them for the back.
// ----------------------------------------------------------------------------
module bir_front import bir_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic               func,
	input  wire logic [COORD_W-1:0] col,
	input  wire logic [COORD_W-1:0] row,
	input  wire logic [PIX_W-1:0]   pixel_in,
	input  wire logic               hold,
	input  wire lim_t               lim,
	input  wire logic               issue,
	output logic                    q_valid,
	output ent_t                    head
);

	localparam int QD = 4;
	localparam int QA = $clog2(QD);

	ent_t              ent_q [QD];
	logic [QA-1:0]     wptr_q;
	logic [QA-1:0]     rptr_q;
	logic [QA:0]       cnt_q;
	ent_t              ent_in;
	logic              acc;

	assign full = hold || (cnt_q == (QA+1)'(QD));
	assign acc  = push && !full;

	always_comb begin
		ent_in.func = func_t'(func);
		ent_in.col  = col;
		ent_in.row  = row;
		ent_in.cx   = (col > lim.ox_max) ? lim.ox_max : col;
		ent_in.cy   = (row > lim.oy_max) ? lim.oy_max : row;
		ent_in.pix  = pixel_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (acc) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (issue) begin
				rptr_q <= rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (QA+1)'(acc) - (QA+1)'(issue);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ent_q[wptr_q] <= ent_in;
		end
	end

	assign q_valid = cnt_q != '0;
	assign head    = ent_q[rptr_q];

endmodule
`default_nettype wire

>>> sv/bir_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bir_back - execution side
// Four-stage pipeline over a parity-banked source store, result queue.
// ----------------------------------------------------------------------------
module bir_back import bir_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int STEP_W    = SRC_AW + FRAC_BITS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	input  wire ent_t               head,
	output logic                    issue,
	input  wire lim_t               lim,
	input  wire logic [STEP_W-1:0]  step_x,
	input  wire logic [STEP_W-1:0]  step_y,
	output logic                    empty,
	input  wire logic               pop,
	output logic [PIX_W-1:0]        sample_value,
	output logic [COORD_W-1:0]      out_col,
	output logic [COORD_W-1:0]      out_row
);

	localparam int PW     = COORD_W + STEP_W;
	localparam int IW     = PW - FRAC_BITS;
	localparam int TW     = FRAC_BITS + 1;
	localparam int VW     = FRAC_BITS + PIX_W + 2;
	localparam int BA_W   = 2 * (SRC_AW - 1);
	localparam int BANK_D = 1 << BA_W;
	localparam int OD     = 8;
	localparam int OA     = $clog2(OD);

	typedef struct packed {
		logic [SRC_AW-1:0] lo;
		logic [SRC_AW-1:0] hi;
		logic [TW-1:0]     t;
	} axis_t;

	typedef struct packed {
		logic [PIX_W-1:0]   val;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} res_t;

	function automatic axis_t axis_map(input logic [PW-1:0] p, input logic [SRC_AW-1:0] m);
		logic [IW-1:0]     raw;
		logic [SRC_AW-1:0] lo;
		logic [SRC_AW-1:0] hi;
		logic [PW-1:0]     hip;
		axis_t             r;
		raw  = p[PW-1:FRAC_BITS];
		lo   = (raw > IW'(m)) ? m : raw[SRC_AW-1:0];
		hi   = (lo < m) ? lo + 1'b1 : m;
		hip  = PW'(hi) << FRAC_BITS;
		r.lo = lo;
		r.hi = hi;
		r.t  = (hip >= p) ? TW'(hip - p) : '0;
		return r;
	endfunction

	// a + t * (b - a) in fixed point, floored; weight t sits on b
	function automatic logic [PIX_W-1:0] blend(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b, input logic [TW-1:0] t);
		logic signed [PIX_W:0]  d;
		logic signed [VW-1:0]   v;
		d = $signed({1'b0, b}) - $signed({1'b0, a});
		v = $signed({2'b00, a, {FRAC_BITS{1'b0}}}) + $signed({1'b0, t}) * d;
		return v[VW-1] ? '0 : v[FRAC_BITS+PIX_W-1:FRAC_BITS];
	endfunction

	// ---- stage registers
	logic               v_s1, smp_s1;
	ent_t               ent_s1;
	logic               v_s2, smp_s2;
	logic [COORD_W-1:0] col_s2, row_s2;
	logic [PIX_W-1:0]   pix_s2;
	logic [PW-1:0]      px_s2, py_s2;
	logic               smp_s3;
	logic [COORD_W-1:0] col_s3, row_s3;
	logic [TW-1:0]      tx_s3, ty_s3;
	logic               x1p_s3, x2p_s3, y1p_s3, y2p_s3;
	logic               smp_s4;
	logic [COORD_W-1:0] col_s4, row_s4;
	logic [TW-1:0]      ty_s4;
	logic [PIX_W-1:0]   top_s4, bot_s4;

	// ---- result queue
	res_t               out_q [OD];
	logic [OA-1:0]      owp_q, orp_q;
	logic [OA:0]        ocnt_q;
	logic               o_pop;

	logic [2:0]         inflight;
	logic [OA+1:0]      need;
	axis_t              ax, ay;
	logic               wr_ok;
	logic [PIX_W-1:0]   rdata [4];
	logic [PIX_W-1:0]   p22, p12, p21, p11, val_s4;

	assign inflight = 3'(smp_s1) + 3'(smp_s2) + 3'(smp_s3) + 3'(smp_s4);
	assign need     = (OA+2)'(ocnt_q) + (OA+2)'(inflight);
	assign issue    = q_valid && (need < (OA+2)'(OD));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			smp_s1 <= 1'b0;
			v_s2   <= 1'b0;
			smp_s2 <= 1'b0;
			smp_s3 <= 1'b0;
			smp_s4 <= 1'b0;
		end else begin
			v_s1   <= issue;
			smp_s1 <= issue && (head.func == FUNC_SAMPLE);
			v_s2   <= v_s1;
			smp_s2 <= smp_s1;
			smp_s3 <= smp_s2;
			smp_s4 <= smp_s3;
		end
	end

	always_ff @(posedge clk) begin
		ent_s1 <= head;
		col_s2 <= ent_s1.col;
		row_s2 <= ent_s1.row;
		pix_s2 <= ent_s1.pix;
		px_s2  <= PW'(ent_s1.cx) * PW'(step_x);
		py_s2  <= PW'(ent_s1.cy) * PW'(step_y);
		col_s3 <= col_s2;
		row_s3 <= row_s2;
		tx_s3  <= ax.t;
		ty_s3  <= ay.t;
		x1p_s3 <= ax.lo[0];
		x2p_s3 <= ax.hi[0];
		y1p_s3 <= ay.lo[0];
		y2p_s3 <= ay.hi[0];
		col_s4 <= col_s3;
		row_s4 <= row_s3;
		ty_s4  <= ty_s3;
		top_s4 <= blend(p22, p12, tx_s3);
		bot_s4 <= blend(p21, p11, tx_s3);
	end

	assign ax    = axis_map(px_s2, lim.ix_max);
	assign ay    = axis_map(py_s2, lim.iy_max);
	assign wr_ok = v_s2 && !smp_s2
		&& ({1'b0, col_s2} < (COORD_W+1)'(MAX_SRC_DIM))
		&& ({1'b0, row_s2} < (COORD_W+1)'(MAX_SRC_DIM));

	// bank b holds column parity b[1] and row parity b[0]
	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic CP = 1'(b / 2);
		localparam logic RP = 1'(b % 2);
		logic [PIX_W-1:0]  mem [BANK_D];
		logic [PIX_W-1:0]  rd_s3;
		logic [SRC_AW-1:0] rc, rr;
		logic [BA_W-1:0]   ra, wa;
		logic              we;

		assign rc = (ax.lo[0] == CP) ? ax.lo : ax.hi;
		assign rr = (ay.lo[0] == RP) ? ay.lo : ay.hi;
		assign ra = {rc[SRC_AW-1:1], rr[SRC_AW-1:1]};
		assign wa = {col_s2[SRC_AW-1:1], row_s2[SRC_AW-1:1]};
		assign we = wr_ok && (col_s2[0] == CP) && (row_s2[0] == RP);

		always_ff @(posedge clk) begin
			if (we) begin
				mem[wa] <= pix_s2;
			end
			rd_s3 <= mem[ra];
		end

		assign rdata[b] = rd_s3;
	end

	assign p22 = rdata[{x2p_s3, y2p_s3}];
	assign p12 = rdata[{x1p_s3, y2p_s3}];
	assign p21 = rdata[{x2p_s3, y1p_s3}];
	assign p11 = rdata[{x1p_s3, y1p_s3}];

	assign val_s4 = blend(top_s4, bot_s4, ty_s4);

	// ---- result queue
	assign empty = ocnt_q == '0;
	assign o_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= '0;
			orp_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (smp_s4) begin
				owp_q <= owp_q + 1'b1;
			end
			if (o_pop) begin
				orp_q <= orp_q + 1'b1;
			end
			ocnt_q <= ocnt_q + (OA+1)'(smp_s4) - (OA+1)'(o_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (smp_s4) begin
			out_q[owp_q] <= '{val: val_s4, col: col_s4, row: row_s4};
		end
	end

	assign sample_value = out_q[orp_q].val;
	assign out_col      = out_q[orp_q].col;
	assign out_row      = out_q[orp_q].row;

endmodule
`default_nettype wire

>>> sv/bir_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bir_checker - port-level checks
// Register-write stall and result hold, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bir_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       push,
	input wire logic       full,
	input wire logic       empty,
	input wire logic       pop,
	input wire logic       cfg_valid,
	input wire logic       cfg_ready,
	input wire logic [7:0] sample_value,
	input wire logic [9:0] out_col,
	input wire logic [9:0] out_row
);

	// a register write must stall items while the steps are rebuilt
	`ASSERT_NEXT(a_cfg_stalls, cfg_valid && cfg_ready, full && !cfg_ready, "items taken during step update")

	`ASSERT_IMPLIES(a_busy_full, !cfg_ready, full, "item side open while dividers run")

	`ASSERT_IMPLIES(a_push_held, push && full && !cfg_ready, !cfg_ready || full, "stall lost")

	`ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(sample_value) && $stable(out_col) && $stable(out_row), "waiting result changed")

endmodule

bind bilinear_image_resampler bir_checker u_bir_checker (.*);
`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - bilinear image resampler
// Drives pixel writes and sample requests through the queue ports, predicts
// every interpolated sample in a scoreboard and checks results in order,
// across several register settings including the extremes.
// ----------------------------------------------------------------------------
module testbench;
	import bir_pkg::*;

	localparam int SCALE   = 16;   // fractional bits of the positions
	localparam int SETTLE  = 40;   // cycles past the last result before idle
	localparam int HOLDOFF = 300;  // long receiver stall, in cycles

	typedef struct {
		logic [PIX_W-1:0]   value;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} sample_t;

	// Predicts interpolated samples and checks them in arrival order.
	class resample_scoreboard;
		logic [PIX_W-1:0] image [MAX_SRC_DIM][MAX_SRC_DIM];
		bit               known [MAX_SRC_DIM][MAX_SRC_DIM];
		logic [OUT_DIM_W-1:0] dims [4];
		sample_t          pending [$];
		int               errors;

		function new();
			dims = '{11'(RST_IN_DIM), 11'(RST_IN_DIM), 11'(RST_OUT_DIM), 11'(RST_OUT_DIM)};
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [OUT_DIM_W-1:0] data);
			if (idx == REG_IN_WIDTH || idx == REG_IN_HEIGHT)
				dims[idx] = {2'b0, data[IN_DIM_W-1:0]};
			else
				dims[idx] = data;
		endfunction

		// dimension actually used: saturated to [1, hi]
		function int eff(int idx);
			int hi, v;
			hi = (idx < 2) ? MAX_SRC_DIM : MAX_DST_DIM;
			v = dims[idx];
			if (v < 1) v = 1;
			if (v > hi) v = hi;
			return v;
		endfunction

		// source position of one axis: lower and upper neighbour, weight
		function void axis(int c, int in_dim, int out_dim,
				output int lo, output int hi, output longint t);
			longint step, p;
			int cc;
			step = (out_dim == 1) ? 0 : ((longint'(in_dim - 1) << SCALE) / (out_dim - 1));
			cc = (c < out_dim) ? c : out_dim - 1;
			p = cc * step;
			lo = int'(p >> SCALE);
			if (lo > in_dim - 1) lo = in_dim - 1;
			hi = (lo + 1 < in_dim) ? lo + 1 : in_dim - 1;
			t = ((longint'(hi) << SCALE) >= p) ? (longint'(hi) << SCALE) - p : 0;
		endfunction

		function int blend(int a, int b, longint t);
			longint v;
			v = (longint'(a) << SCALE) + t * (b - a);
			if (v < 0) v = 0;
			return int'(v >> SCALE) & 8'hff;
		endfunction

		function void note(func_t f, logic [COORD_W-1:0] c, logic [COORD_W-1:0] r,
				logic [PIX_W-1:0] p);
			int x1, x2, y1, y2, top, bot;
			longint tx, ty;
			sample_t s;
			if (f == FUNC_WRITE) begin
				if (c < MAX_SRC_DIM && r < MAX_SRC_DIM) begin
					image[c][r] = p;
					known[c][r] = 1'b1;
				end
				return;
			end
			axis(c, eff(0), eff(2), x1, x2, tx);
			axis(r, eff(1), eff(3), y1, y2, ty);
			top = blend(image[x2][y2], image[x1][y2], tx);
			bot = blend(image[x2][y1], image[x1][y1], tx);
			s.value = PIX_W'(blend(top, bot, ty));
			s.col = c;
			s.row = r;
			pending.push_back(s);
		endfunction

		function void check(logic [PIX_W-1:0] v, logic [COORD_W-1:0] c,
				logic [COORD_W-1:0] r);
			sample_t s;
			if (pending.size() == 0) begin
				$error("sample (%0d,%0d) = %0d arrived with nothing expected", c, r, v);
				errors++;
				return;
			end
			s = pending.pop_front();
			if (v !== s.value) begin
				$error("sample_value: expected %0d, actual %0d", s.value, v);
				errors++;
			end
			if (c !== s.col) begin
				$error("out_col: expected %0d, actual %0d", s.col, c);
				errors++;
			end
			if (r !== s.row) begin
				$error("out_row: expected %0d, actual %0d", s.row, r);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	logic                 func;
	logic [COORD_W-1:0]   col;
	logic [COORD_W-1:0]   row;
	logic [PIX_W-1:0]     pixel_in;
	logic                 empty;
	logic                 pop;
	logic [PIX_W-1:0]     sample_value;
	logic [COORD_W-1:0]   out_col;
	logic [COORD_W-1:0]   out_row;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [OUT_DIM_W-1:0] cfg_data;

	resample_scoreboard sb;
	int  burst_left;    // items left in the current sender burst
	bit  no_gaps;       // sender offers back to back when set
	bit  hold_req;      // asks the receiver for one long stall
	int  hold_left;
	int  rx_cyc;

	bilinear_image_resampler i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.func        (func),
		.col         (col),
		.row         (row),
		.pixel_in    (pixel_in),
		.empty       (empty),
		.pop         (pop),
		.sample_value(sample_value),
		.out_col     (out_col),
		.out_row     (out_row),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Receiver: cycles through full-rate, patchy and periodic stalls; a long
	// hold-off is counted here when the stimulus asks for one.
	always @(negedge clk) begin
		rx_cyc++;
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLDOFF;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			case (rx_cyc[9:8])
				2'd0: pop <= 1'b1;
				2'd1: pop <= ($urandom_range(0, 1) == 0);
				2'd2: pop <= ($urandom_range(0, 9) != 0);
				default: pop <= (rx_cyc[2:0] != 3'd0);
			endcase
		end
	end

	// results are taken at the rising edge, before the block updates
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check(sample_value, out_col, out_row);
	end

	// One item on the input queue; bursts and gaps are decided here.
	task automatic send(func_t f, logic [COORD_W-1:0] c, logic [COORD_W-1:0] r,
			logic [PIX_W-1:0] p);
		int gap;
		if (burst_left == 0) begin
			gap = no_gaps ? 0 : $urandom_range(0, 6);
			repeat (gap) begin
				@(negedge clk);
				push <= 1'b0;
			end
			burst_left = $urandom_range(1, 24);
		end
		@(negedge clk);
		push <= 1'b1;
		func <= f;
		col <= c;
		row <= r;
		pixel_in <= p;
		forever begin
			@(posedge clk);
			if (!full) break;
		end
		sb.note(f, c, r, p);
		burst_left--;
	endtask

	// Sample request; neighbours not yet written are written first so that
	// no unwritten pixel is ever read.
	task automatic sample_at(logic [COORD_W-1:0] c, logic [COORD_W-1:0] r);
		int x1, x2, y1, y2;
		longint tx, ty;
		sb.axis(c, sb.eff(0), sb.eff(2), x1, x2, tx);
		sb.axis(r, sb.eff(1), sb.eff(3), y1, y2, ty);
		if (!sb.known[x1][y1]) send(FUNC_WRITE, COORD_W'(x1), COORD_W'(y1), 8'($urandom));
		if (!sb.known[x2][y1]) send(FUNC_WRITE, COORD_W'(x2), COORD_W'(y1), 8'($urandom));
		if (!sb.known[x1][y2]) send(FUNC_WRITE, COORD_W'(x1), COORD_W'(y2), 8'($urandom));
		if (!sb.known[x2][y2]) send(FUNC_WRITE, COORD_W'(x2), COORD_W'(y2), 8'($urandom));
		send(FUNC_SAMPLE, c, r, 8'($urandom));
	endtask

	// Let every expected sample come out, then let trailing writes in the
	// pipeline settle.
	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		burst_left = 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [OUT_DIM_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_dims(int iw, int ih, int ow, int oh);
		drain();
		write_reg(REG_IN_WIDTH, OUT_DIM_W'(iw));
		write_reg(REG_IN_HEIGHT, OUT_DIM_W'(ih));
		write_reg(REG_OUT_WIDTH, OUT_DIM_W'(ow));
		write_reg(REG_OUT_HEIGHT, OUT_DIM_W'(oh));
	endtask

	// Random phase: mostly in-range samples, some at and past the output
	// edge or anywhere in the field, and writes that sometimes miss storage.
	task automatic random_phase(int items);
		int k, sel, ow, oh, iw, ih;
		logic [COORD_W-1:0] c, r;
		for (k = 0; k < items; k++) begin
			iw = sb.eff(0);
			ih = sb.eff(1);
			ow = sb.eff(2);
			oh = sb.eff(3);
			sel = $urandom_range(0, 9);
			if (sel < 3) begin
				if (sel == 0) begin
					c = COORD_W'($urandom);
					r = COORD_W'($urandom);
				end else begin
					c = COORD_W'($urandom_range(0, iw - 1));
					r = COORD_W'($urandom_range(0, ih - 1));
				end
				send(FUNC_WRITE, c, r, 8'($urandom));
			end else begin
				if (sel < 8) begin
					c = COORD_W'($urandom_range(0, ow - 1));
					r = COORD_W'($urandom_range(0, oh - 1));
				end else if (sel == 8) begin
					c = COORD_W'($urandom_range(ow - 1, (ow + 3 > 1023) ? 1023 : ow + 3));
					r = COORD_W'($urandom_range(oh - 1, (oh + 3 > 1023) ? 1023 : oh + 3));
				end else begin
					c = COORD_W'($urandom);
					r = COORD_W'($urandom);
				end
				sample_at(c, r);
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		push = 1'b0;
		func = FUNC_WRITE;
		col = '0;
		row = '0;
		pixel_in = '0;
		pop = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_IN_WIDTH;
		cfg_data = '0;
		burst_left = 0;
		no_gaps = 1'b0;
		hold_req = 1'b0;
		hold_left = 0;
		rx_cyc = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// directed, reset dimensions: corners, full-scale pixels, writes
		// outside storage, requests past the output edge
		send(FUNC_WRITE, 10'd0, 10'd0, 8'hff);
		send(FUNC_WRITE, 10'd1, 10'd0, 8'h00);
		send(FUNC_WRITE, 10'd0, 10'd1, 8'h55);
		send(FUNC_WRITE, 10'd1, 10'd1, 8'haa);
		send(FUNC_WRITE, 10'd1023, 10'd1023, 8'h0f);
		send(FUNC_WRITE, 10'd300, 10'd5, 8'hf0);
		send(FUNC_WRITE, 10'd5, 10'd256, 8'h12);
		sample_at(10'd0, 10'd0);
		sample_at(10'd1, 10'd1);
		sample_at(10'd255, 10'd255);
		sample_at(10'd1023, 10'd1023);
		sample_at(10'd256, 10'd0);
		sample_at(10'd0, 10'd512);

		// single output pixel, and zero acting as one
		set_dims(256, 256, 1, 1);
		sample_at(10'd0, 10'd0);
		sample_at(10'd700, 10'd3);
		set_dims(0, 0, 0, 0);
		sample_at(10'd0, 10'd0);
		sample_at(10'd1023, 10'd1);
		// above range on every register
		set_dims(2047, 2047, 2047, 2047);
		sample_at(10'd1023, 10'd1023);
		sample_at(10'd511, 10'd0);

		// long receiver stall while the sender keeps offering
		set_dims(256, 256, 1024, 1024);
		no_gaps = 1'b1;
		hold_req = 1'b1;
		random_phase(70);
		no_gaps = 1'b0;
		drain();   // sender waits for every sample
		random_phase(25);

		set_dims(2, 3, 7, 5);
		random_phase(70);
		set_dims(1, 1, 1024, 3);
		random_phase(30);
		set_dims($urandom_range(1, 16), $urandom_range(1, 16),
			$urandom_range(1, 40), $urandom_range(1, 40));
		random_phase(70);
		set_dims(256, 1, 2, 1024);
		random_phase(40);
		set_dims(16, 16, 1000, 1000);
		random_phase(70);
		set_dims(256, 256, 256, 256);
		random_phase(30);

		drain();
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
